// ----- src/s256_pkg.sv -----
// SHA-256 stream hasher package: sequencer states, initial hash values,
// round constants and the sigma functions of the compression round.
// Depends on nothing; imported by sha256_stream_hasher_core.
`default_nettype none

package s256_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_FOLD,
      S_OUT
   } state_type;

   typedef logic [31:0] word_type;

   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

// ----- src/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher: byte-serial gather, padding and one-round-per-cycle
// compression, then eight digest words out. Depends on s256_pkg.
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  req     | in        | req_valid/req_ready  | msg_byte, byte_present, end_of_message
//  rsp     | out       | rsp_valid/rsp_ready  | digest_word, word_index, last_word
//
//  Flow: a request that does not fill a block is taken whenever ready is high. Filling
//  the 64th byte of a block starts 64 rounds on the shared round unit, then one
//  fold of the working words into the chaining words; ready is low meanwhile.
//  Closing a message: padding/length bytes are shifted in up to the block end,
//  one or two compressions follow, then eight response words, one per accepted beat.
//  Reset is synchronous; no clearing pass is needed.
//  A stalled response holds its word; no request is taken until the eighth goes.

module sha256_stream_hasher_core #(
   parameter int LENGTH_COUNTER_BITS = 64
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_valid,
   output       logic                  req_ready,
   input  wire  logic [7:0]            req_msg_byte,
   input  wire  logic                  req_byte_present,
   input  wire  logic                  req_end_of_message,
   output       logic                  rsp_valid,
   input  wire  logic                  rsp_ready,
   output       s256_pkg::word_type    rsp_digest_word,
   output       logic [2:0]            rsp_word_index,
   output       logic                  rsp_last_word
);
   import s256_pkg::*;

   // Only the low LENGTH_COUNTER_BITS of the bit length reach the digest, so
   // keep just the byte-count bits that feed them.
   localparam int CNT_W = LENGTH_COUNTER_BITS - 3;

   state_type          state_ff, state_in;
   logic [511:0]       blk_ff, blk_in;      // block gather and rolling schedule
   word_type           wv_ff [8];
   word_type           wv_in [8];
   word_type           h_ff [8];
   word_type           h_in [8];
   logic [5:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic               closing_ff, closing_in;
   logic               pad_first_ff, pad_first_in;
   logic               len_here_ff, len_here_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         idx_ff, idx_in;

   // Round unit
   word_type           w_cur, w_next, t1, t2, ch, maj;
   logic [63:0]        bit_len;
   logic [2:0]         len_sel;
   logic [7:0]         len_byte, pad_byte;

   assign w_cur  = blk_ff[511:480];
   assign w_next = small_sigma1(blk_ff[63:32]) + blk_ff[223:192]
                 + small_sigma0(blk_ff[479:448]) + w_cur;
   assign ch     = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
   assign maj    = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
   assign t1     = wv_ff[7] + big_sigma1(wv_ff[4]) + ch + ROUND_K[rnd_ff] + w_cur;
   assign t2     = big_sigma0(wv_ff[0]) + maj;

   // Padding byte: marker first, then zeros, with the big-endian bit length in
   // the last eight slots of the block that carries it.
   assign bit_len  = 64'({cnt_ff, 3'b000});
   assign len_sel  = WORD_LAST - pos_ff[2:0];
   assign len_byte = bit_len[{len_sel, 3'b000} +: 8];
   assign pad_byte = pad_first_ff ? PAD_BYTE
                   : ((len_here_ff && pos_ff >= LEN_POS) ? len_byte : 8'h00);

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      closing_in   = closing_ff;
      pad_first_in = pad_first_ff;
      len_here_in  = len_here_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      wv_in        = wv_ff;
      h_in         = h_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_byte_present) begin
                  blk_in = {blk_ff[503:0], req_msg_byte};
                  cnt_in = cnt_ff + 1'b1;
                  pos_in = pos_ff + 1'b1;
               end
               if (req_end_of_message) begin
                  closing_in   = 1'b1;
                  pad_first_in = 1'b1;
                  len_here_in  = 1'b0;
               end
               if (req_byte_present && pos_ff == POS_LAST) begin
                  state_in = S_ROUND;
                  rnd_in   = '0;
                  wv_in    = h_ff;
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            blk_in       = {blk_ff[503:0], pad_byte};
            pos_in       = pos_ff + 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               len_here_in = (pos_ff < LEN_POS);
            end
            if (pos_ff == POS_LAST) begin
               state_in = S_ROUND;
               rnd_in   = '0;
               wv_in    = h_ff;
            end
         end
         S_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            blk_in   = {blk_ff[479:0], w_next};
            rnd_in   = rnd_ff + 1'b1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + wv_ff[i];
            end
            if (!closing_ff) begin
               state_in = S_IDLE;
            end else if (len_here_ff) begin
               state_in     = S_OUT;
               rsp_valid_in = 1'b1;
               idx_in       = '0;
            end else begin
               if (!pad_first_ff) begin
                  len_here_in = 1'b1;
               end
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (idx_ff == WORD_LAST) begin
                  h_in         = INIT_HASH;
                  cnt_in       = '0;
                  pos_in       = '0;
                  closing_in   = 1'b0;
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         closing_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         len_here_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         h_ff         <= INIT_HASH;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         closing_ff   <= closing_in;
         pad_first_ff <= pad_first_in;
         len_here_ff  <= len_here_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         h_ff         <= h_in;
      end
   end

   // Block and working words carry no reset: every use follows a load.
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      wv_ff  <= wv_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == WORD_LAST);

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT)
      else $error("response valid outside output state");

   a_out_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> pos_ff == '0)
      else $error("digest out with a partly filled block");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (state_ff == S_IDLE && cnt_ff == '0))
      else $error("hasher not rearmed after final digest word");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rnd_ff == ROUND_LAST) |=> state_ff == S_FOLD)
      else $error("fold missing after last round");

   a_pad_closing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PAD |-> closing_ff)
      else $error("padding without a closing request");

endmodule

`default_nettype wire
